FILE: sv/hexnb_pkg.sv
// Shared constants and types for the hex lattice neighbor indexer.
// No dependencies; used by hex_lattice_neighbor_index.

package hexnb_pkg;

    // Field widths
    localparam int COORD_W  = 10;   // cell column / row
    localparam int CFG_W    = 11;   // width / height registers
    localparam int SIDE_W   = 12;   // effective side, up to 2048
    localparam int AXIS_W   = 11;   // wrapped neighbor column / row
    localparam int IDX_W    = 20;   // linear neighbor index
    localparam int DIR_W    = 3;
    localparam int DIR_N    = 6;    // left, right, lower-l, lower-r, upper-l, upper-r
    localparam int ROW_N    = 3;    // rows r-1, r, r+1
    localparam int PROD_W   = AXIS_W + SIDE_W;

    localparam int MAX_SIDE_DEFAULT = 1024;

    // Configuration bus
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_WRAP_COLS   = 2'd2,
        REG_WRAP_ROWS   = 2'd3
    } cfg_reg_t;

    // Row selection per direction
    localparam logic [1:0] ROW_ABOVE = 2'd0;   // r-1
    localparam logic [1:0] ROW_SAME  = 2'd1;   // r
    localparam logic [1:0] ROW_BELOW = 2'd2;   // r+1

endpackage

FILE: sv/hex_lattice_neighbor_index.sv
// Path: a request accepted at the input passes through the stage 1, stage 2 and
// stage 3 registers and then the result buffer before its first result is driven.
// Throughput: one result per cycle while m_tready is high; a query gives 1 to 6
// results (6 for an interior cell) and holds the result channel until its last result is taken. A new
// request can be taken every cycle while the 3-stage pipe has room.
// Reset: width and height 2, no wrapping, pipeline and result buffer empty.
//
// Hex lattice neighbor indexer (offset rows, odd rows shifted right).
// Depends on hexnb_pkg.

module hex_lattice_neighbor_index #(
    parameter int MAX_SIDE = hexnb_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // Query stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // [9:0] cell_column, [19:10] cell_row
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [19:0] neighbor_index,
                                                      // [22:20] direction,
                                                      // [25:23] neighbor_total
    output logic                           m_tlast,
    output logic [0:0]                     m_tuser,   // [0] bad_cell

    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hexnb_pkg::PADDR_W-1:0]  paddr,
    input  logic [hexnb_pkg::PDATA_W-1:0]  pwdata,
    output logic [hexnb_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);

    localparam int CW  = hexnb_pkg::COORD_W;
    localparam int FW  = hexnb_pkg::CFG_W;
    localparam int SW  = hexnb_pkg::SIDE_W;
    localparam int AW  = hexnb_pkg::AXIS_W;
    localparam int IW  = hexnb_pkg::IDX_W;
    localparam int DW  = hexnb_pkg::DIR_W;
    localparam int DN  = hexnb_pkg::DIR_N;
    localparam int RN  = hexnb_pkg::ROW_N;
    localparam int PW  = hexnb_pkg::PROD_W;
    localparam logic [16:0] MaxSide = 17'(MAX_SIDE);

    localparam int ROW_ABOVE_I = int'(hexnb_pkg::ROW_ABOVE);
    localparam int ROW_SAME_I  = int'(hexnb_pkg::ROW_SAME);
    localparam int ROW_BELOW_I = int'(hexnb_pkg::ROW_BELOW);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FW-1:0] grid_width_reg, grid_width_next;
    logic [FW-1:0] grid_height_reg, grid_height_next;
    logic          wrap_cols_reg, wrap_cols_next;
    logic          wrap_rows_reg, wrap_rows_next;
    logic          cfg_write;
    hexnb_pkg::cfg_reg_t cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = hexnb_pkg::cfg_reg_t'(paddr[3:2]);

    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        wrap_cols_next   = wrap_cols_reg;
        wrap_rows_next   = wrap_rows_reg;
        if (cfg_write)
        begin
            case (cfg_sel)
                hexnb_pkg::REG_GRID_WIDTH:  grid_width_next  = pwdata[FW-1:0];
                hexnb_pkg::REG_GRID_HEIGHT: grid_height_next = pwdata[FW-1:0];
                hexnb_pkg::REG_WRAP_COLS:   wrap_cols_next   = pwdata[0];
                hexnb_pkg::REG_WRAP_ROWS:   wrap_rows_next   = pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (cfg_sel)
            hexnb_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width_reg);
            hexnb_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height_reg);
            hexnb_pkg::REG_WRAP_COLS:   prdata = 32'(wrap_cols_reg);
            hexnb_pkg::REG_WRAP_ROWS:   prdata = 32'(wrap_rows_reg);
            default:                    prdata = '0;
        endcase
    end

    // Effective sides: round up to even, clamp to MAX_SIDE
    function automatic logic [SW-1:0] eff_side(input logic [FW-1:0] v);
        logic [SW-1:0] e;
        e = SW'(v) + SW'(v[0]);
        if (17'(e) > MaxSide)
            e = MaxSide[SW-1:0];
        return e;
    endfunction

    logic [SW-1:0] w_eff, h_eff;
    assign w_eff = eff_side(grid_width_reg);
    assign h_eff = eff_side(grid_height_reg);

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s1_ready, s2_ready, s3_ready;
    logic in_fire, out_fire, out_last;

    // ------------------------------------------------------------------
    // Stage 1: bounds check, wrapped neighbor columns and rows, mask
    // ------------------------------------------------------------------
    logic [CW-1:0] in_col, in_row;
    logic [AW-1:0] c_ext, r_ext, c_p1, r_p1;
    logic [SW-1:0] w_m1, h_m1;
    logic [AW-1:0] col_m, col_p, row_m, row_p;
    logic          v_cm, v_cp, v_rm, v_rp, odd, bad;

    logic          s1_bad_reg, s1_bad_next;
    logic [DN-1:0] s1_mask_reg, s1_mask_next;
    logic [AW-1:0] s1_col_reg [DN];
    logic [AW-1:0] s1_col_next [DN];
    logic [AW-1:0] s1_row_reg [RN];
    logic [AW-1:0] s1_row_next [RN];

    assign in_col = s_tdata[CW-1:0];
    assign in_row = s_tdata[2*CW-1:CW];

    always_comb
    begin
        c_ext = AW'(in_col);
        r_ext = AW'(in_row);
        c_p1  = c_ext + AW'(1);
        r_p1  = r_ext + AW'(1);
        w_m1  = w_eff - SW'(1);
        h_m1  = h_eff - SW'(1);
        bad   = (SW'(in_col) >= w_eff) || (SW'(in_row) >= h_eff);
        odd   = in_row[0];

        // Horizontal neighbors with wrap
        col_m = (in_col == '0) ? w_m1[AW-1:0] : c_ext - AW'(1);
        col_p = (SW'(c_p1) == w_eff) ? '0 : c_p1;
        v_cm  = (in_col != '0) || wrap_cols_reg;
        v_cp  = (SW'(c_p1) != w_eff) || wrap_cols_reg;

        // Vertical neighbors with wrap
        row_m = (in_row == '0) ? h_m1[AW-1:0] : r_ext - AW'(1);
        row_p = (SW'(r_p1) == h_eff) ? '0 : r_p1;
        v_rm  = (in_row != '0) || wrap_rows_reg;
        v_rp  = (SW'(r_p1) != h_eff) || wrap_rows_reg;

        s1_col_next[0] = col_m;
        s1_col_next[1] = col_p;
        s1_col_next[2] = odd ? c_ext : col_m;
        s1_col_next[3] = odd ? col_p : c_ext;
        s1_col_next[4] = odd ? c_ext : col_m;
        s1_col_next[5] = odd ? col_p : c_ext;
        s1_row_next[ROW_ABOVE_I] = row_m;
        s1_row_next[ROW_SAME_I]  = r_ext;
        s1_row_next[ROW_BELOW_I] = row_p;

        s1_mask_next[0] = v_cm;
        s1_mask_next[1] = v_cp;
        s1_mask_next[2] = v_rm && (odd || v_cm);
        s1_mask_next[3] = v_rm && (!odd || v_cp);
        s1_mask_next[4] = v_rp && (odd || v_cm);
        s1_mask_next[5] = v_rp && (!odd || v_cp);
        s1_bad_next     = bad;

        // Outside the grid: one result, index zero
        if (bad)
        begin
            s1_mask_next = DN'(1);
            for (int i = 0; i < DN; i++)
                s1_col_next[i] = '0;
            for (int i = 0; i < RN; i++)
                s1_row_next[i] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: row base products, neighbor count
    // ------------------------------------------------------------------
    logic          s2_bad_reg;
    logic [DN-1:0] s2_mask_reg;
    logic [DW-1:0] s2_total_reg, s2_total_next;
    logic [AW-1:0] s2_col_reg [DN];
    logic [IW-1:0] s2_prod_reg [RN];
    logic [IW-1:0] s2_prod_next [RN];
    logic [PW-1:0] prod_full [RN];

    always_comb
    begin
        for (int k = 0; k < RN; k++)
        begin
            prod_full[k]    = PW'(s1_row_reg[k]) * PW'(w_eff);
            s2_prod_next[k] = prod_full[k][IW-1:0];
        end
        s2_total_next = '0;
        for (int i = 0; i < DN; i++)
            s2_total_next = s2_total_next + DW'(s1_mask_reg[i]);
        if (s1_bad_reg)
            s2_total_next = '0;
    end

    // ------------------------------------------------------------------
    // Stage 3: add columns to row bases
    // ------------------------------------------------------------------
    logic          s3_bad_reg;
    logic [DN-1:0] s3_mask_reg;
    logic [DW-1:0] s3_total_reg;
    logic [IW-1:0] s3_idx_reg [DN];
    logic [IW-1:0] s3_idx_next [DN];

    always_comb
    begin
        s3_idx_next[0] = s2_prod_reg[ROW_SAME_I]  + IW'(s2_col_reg[0]);
        s3_idx_next[1] = s2_prod_reg[ROW_SAME_I]  + IW'(s2_col_reg[1]);
        s3_idx_next[2] = s2_prod_reg[ROW_ABOVE_I] + IW'(s2_col_reg[2]);
        s3_idx_next[3] = s2_prod_reg[ROW_ABOVE_I] + IW'(s2_col_reg[3]);
        s3_idx_next[4] = s2_prod_reg[ROW_BELOW_I] + IW'(s2_col_reg[4]);
        s3_idx_next[5] = s2_prod_reg[ROW_BELOW_I] + IW'(s2_col_reg[5]);
    end

    // ------------------------------------------------------------------
    // Result buffer: emits the set mask bits, lowest direction first
    // ------------------------------------------------------------------
    logic [DN-1:0] ser_mask_reg, ser_mask_next;
    logic          ser_bad_reg;
    logic [DW-1:0] ser_total_reg;
    logic [IW-1:0] ser_idx_reg [DN];
    logic [DW-1:0] out_dir;
    logic          ser_free, ser_load;

    always_comb
    begin
        out_dir = '0;
        for (int d = DN - 1; d >= 0; d--)
            if (ser_mask_reg[d])
                out_dir = DW'(d);
    end

    assign m_tvalid = (ser_mask_reg != '0);
    assign out_last = ((ser_mask_reg & (ser_mask_reg - DN'(1))) == '0);
    assign out_fire = m_tvalid && m_tready;
    assign m_tlast  = out_last;
    assign m_tuser  = ser_bad_reg;
    assign m_tdata  = {6'd0, ser_total_reg, out_dir, ser_idx_reg[out_dir]};

    assign ser_free = !m_tvalid || (out_fire && out_last);
    assign ser_load = s3_valid_reg && ser_free;

    // Ready chain back through the stages
    assign s3_ready = ser_free;
    assign s2_ready = !s3_valid_reg || s3_ready;
    assign s1_ready = !s2_valid_reg || s2_ready;
    assign s_tready = !s1_valid_reg || s1_ready;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s_tready ? s_tvalid : s1_valid_reg;
        s2_valid_next = s1_ready ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s2_ready ? s2_valid_reg : s3_valid_reg;
        ser_mask_next = ser_mask_reg;
        if (ser_load)
            ser_mask_next = s3_mask_reg;
        else if (out_fire)
            ser_mask_next = ser_mask_reg & (ser_mask_reg - DN'(1));
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= FW'(2);
            grid_height_reg <= FW'(2);
            wrap_cols_reg   <= 1'b0;
            wrap_rows_reg   <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            ser_mask_reg    <= '0;
        end
        else
        begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            wrap_cols_reg   <= wrap_cols_next;
            wrap_rows_reg   <= wrap_rows_next;
            s1_valid_reg    <= s1_valid_next;
            s2_valid_reg    <= s2_valid_next;
            s3_valid_reg    <= s3_valid_next;
            ser_mask_reg    <= ser_mask_next;
        end
    end

    // Payload, moves with its valid bit
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_bad_reg  <= s1_bad_next;
            s1_mask_reg <= s1_mask_next;
            s1_col_reg  <= s1_col_next;
            s1_row_reg  <= s1_row_next;
        end
        if (s1_ready && s1_valid_reg)
        begin
            s2_bad_reg   <= s1_bad_reg;
            s2_mask_reg  <= s1_mask_reg;
            s2_total_reg <= s2_total_next;
            s2_col_reg   <= s1_col_reg;
            s2_prod_reg  <= s2_prod_next;
        end
        if (s2_ready && s2_valid_reg)
        begin
            s3_bad_reg   <= s2_bad_reg;
            s3_mask_reg  <= s2_mask_reg;
            s3_total_reg <= s2_total_reg;
            s3_idx_reg   <= s3_idx_next;
        end
        if (ser_load)
        begin
            ser_bad_reg   <= s3_bad_reg;
            ser_total_reg <= s3_total_reg;
            ser_idx_reg   <= s3_idx_reg;
        end
    end

endmodule

FILE: sim/tb_hex_lattice_neighbor_index.sv
`timescale 1ns / 1ps
// Testbench for hex_lattice_neighbor_index: streams cell queries, predicts the
// neighbor list of each one and checks every result in order.
// Depends on hexnb_pkg and hex_lattice_neighbor_index.

// Neighbor directions in the order the block emits them
typedef enum logic [2:0] {
    DIR_LEFT        = 3'd0,
    DIR_RIGHT       = 3'd1,
    DIR_LOWER_LEFT  = 3'd2,
    DIR_LOWER_RIGHT = 3'd3,
    DIR_UPPER_LEFT  = 3'd4,
    DIR_UPPER_RIGHT = 3'd5
} nb_dir_t;

typedef struct {
    logic [19:0] index;
    logic [2:0]  dir;
    logic [2:0]  total;
    logic        last;
    logic        bad;
} nb_result_t;

// Neighbor predictor plus in-order result checker
class neighbor_scoreboard;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic        wrap_cols;
    logic        wrap_rows;
    nb_result_t  expected_q[$];
    int          queries;
    int          bad_queries;
    int          results;
    int          fails;

    function new();
        width_reg   = 11'd2;
        height_reg  = 11'd2;
        wrap_cols   = 1'b0;
        wrap_rows   = 1'b0;
        queries     = 0;
        bad_queries = 0;
        results     = 0;
        fails       = 0;
    endfunction

    // Round up to even, clamp at the largest side
    function int side_of(logic [10:0] v);
        int e;
        e = int'(v) + int'(v[0]);
        if (e > hexnb_pkg::MAX_SIDE_DEFAULT)
            e = hexnb_pkg::MAX_SIDE_DEFAULT;
        return e;
    endfunction

    function void set_reg(hexnb_pkg::cfg_reg_t which, logic [31:0] value);
        case (which)
            hexnb_pkg::REG_GRID_WIDTH:  width_reg  = value[10:0];
            hexnb_pkg::REG_GRID_HEIGHT: height_reg = value[10:0];
            hexnb_pkg::REG_WRAP_COLS:   wrap_cols  = value[0];
            default:                    wrap_rows  = value[0];
        endcase
    endfunction

    function logic [31:0] reg_value(hexnb_pkg::cfg_reg_t which);
        case (which)
            hexnb_pkg::REG_GRID_WIDTH:  return {21'd0, width_reg};
            hexnb_pkg::REG_GRID_HEIGHT: return {21'd0, height_reg};
            hexnb_pkg::REG_WRAP_COLS:   return {31'd0, wrap_cols};
            default:                    return {31'd0, wrap_rows};
        endcase
    endfunction

    // Work out the neighbor list of an accepted query
    function void note_query(logic [9:0] col, logic [9:0] row);
        int         w, h, c, r, nc, nr, n;
        int         idx_list[6];
        int         dir_list[6];
        nb_result_t res;
        w = side_of(width_reg);
        h = side_of(height_reg);
        c = int'(col);
        r = int'(row);
        n = 0;
        queries++;
        if (w == 0 || h == 0 || c >= w || r >= h) begin
            res.index = '0;
            res.dir   = DIR_LEFT;
            res.total = '0;
            res.last  = 1'b1;
            res.bad   = 1'b1;
            expected_q.push_back(res);
            bad_queries++;
            return;
        end
        for (int d = 0; d < hexnb_pkg::DIR_N; d++) begin
            // lower means row r-1, upper row r+1; odd rows sit half a cell right
            case (nb_dir_t'(d))
                DIR_LEFT:        begin nc = c - 1; nr = r; end
                DIR_RIGHT:       begin nc = c + 1; nr = r; end
                DIR_LOWER_LEFT:  begin nc = row[0] ? c : c - 1; nr = r - 1; end
                DIR_LOWER_RIGHT: begin nc = row[0] ? c + 1 : c; nr = r - 1; end
                DIR_UPPER_LEFT:  begin nc = row[0] ? c : c - 1; nr = r + 1; end
                default:         begin nc = row[0] ? c + 1 : c; nr = r + 1; end
            endcase
            if ((nc < 0 || nc >= w) && !wrap_cols)
                continue;
            if ((nr < 0 || nr >= h) && !wrap_rows)
                continue;
            nc = (nc + w) % w;
            nr = (nr + h) % h;
            idx_list[n] = nr * w + nc;
            dir_list[n] = d;
            n++;
        end
        for (int k = 0; k < n; k++) begin
            res.index = idx_list[k][19:0];
            res.dir   = dir_list[k][2:0];
            res.total = n[2:0];
            res.last  = (k == n - 1);
            res.bad   = 1'b0;
            expected_q.push_back(res);
        end
    endfunction

    function void mismatch(string field, logic [31:0] want, logic [31:0] got);
        fails++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(logic [31:0] data, logic last, logic bad);
        nb_result_t want;
        results++;
        if (expected_q.size() == 0) begin
            mismatch("unexpected result, data", 32'd0, data);
            return;
        end
        want = expected_q.pop_front();
        if (data[19:0] !== want.index)
            mismatch("neighbor_index", {12'd0, want.index}, {12'd0, data[19:0]});
        if (data[22:20] !== want.dir)
            mismatch("direction", {29'd0, want.dir}, {29'd0, data[22:20]});
        if (data[25:23] !== want.total)
            mismatch("neighbor_total", {29'd0, want.total}, {29'd0, data[25:23]});
        if (last !== want.last)
            mismatch("last", {31'd0, want.last}, {31'd0, last});
        if (bad !== want.bad)
            mismatch("bad_cell", {31'd0, want.bad}, {31'd0, bad});
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_hex_lattice_neighbor_index;

    localparam int CYCLE_LIMIT = 400000;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [23:0]                    s_tdata;   // [9:0] cell_column, [19:10] cell_row
    logic                           m_tvalid;
    logic                           m_tready;
    logic [31:0]                    m_tdata;   // [19:0] neighbor_index, [22:20] direction,
                                               // [25:23] neighbor_total
    logic                           m_tlast;
    logic [0:0]                     m_tuser;   // [0] bad_cell
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [hexnb_pkg::PADDR_W-1:0]  paddr;
    logic [hexnb_pkg::PDATA_W-1:0]  pwdata;
    logic [hexnb_pkg::PDATA_W-1:0]  prdata;
    logic                           pready;

    neighbor_scoreboard  sb;
    int                  cycle_count = 0;
    int                  rx_wait = 0;
    int                  grid_settings;
    bit                  tx_calm;
    bit                  rx_calm;

    hex_lattice_neighbor_index DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: check each accepted result, then stall a random while
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tlast, m_tuser[0]);
            rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
        end
        if (rx_wait > 0)
        begin
            m_tready <= 1'b0;
            rx_wait--;
        end
        else
            m_tready <= 1'b1;
    end

    // Hold off queries until every expected result is in, then let the pipe empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // One register write followed by a read back
    task automatic write_reg(input hexnb_pkg::cfg_reg_t which, input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hexnb_pkg::PADDR_W'({which, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(which, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== sb.reg_value(which))
        begin
            sb.fails++;
            $display("%0t: register %s read back mismatch, expected %0h, got %0h",
                     $time, which.name(), sb.reg_value(which), readback);
        end
    endtask

    task automatic set_grid(input logic [31:0] w, input logic [31:0] h,
                            input logic [31:0] wc, input logic [31:0] wr);
        drain_results();
        write_reg(hexnb_pkg::REG_GRID_WIDTH, w);
        write_reg(hexnb_pkg::REG_GRID_HEIGHT, h);
        write_reg(hexnb_pkg::REG_WRAP_COLS, wc);
        write_reg(hexnb_pkg::REG_WRAP_ROWS, wr);
        grid_settings++;
    endtask

    // Present one query after a random gap and wait for it to be taken
    task automatic send_query(input logic [9:0] col, input logic [9:0] row);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, row, col};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_query(col, row);
    endtask

    // Mostly cells inside the grid, rims favored, some coordinates anywhere
    task automatic random_query();
        int          w, h, pick;
        logic [9:0]  col, row;
        w = sb.side_of(sb.width_reg);
        h = sb.side_of(sb.height_reg);
        pick = $urandom_range(0, 99);
        if (pick < 15 || w == 0 || h == 0)
        begin
            col = 10'($urandom_range(0, 1023));
            row = 10'($urandom_range(0, 1023));
        end
        else if (pick < 40)
        begin
            col = $urandom_range(0, 1) ? 10'(w - 1) : 10'd0;
            row = $urandom_range(0, 1) ? 10'(h - 1) : 10'd0;
            if ($urandom_range(0, 1))
                col = 10'($urandom_range(0, w - 1));
        end
        else
        begin
            col = 10'($urandom_range(0, w - 1));
            row = 10'($urandom_range(0, h - 1));
        end
        send_query(col, row);
    endtask

    // Register value: mostly small grids, a few empty or oversized ones,
    // with junk above the register's width
    function automatic logic [31:0] random_side();
        logic [10:0] v;
        case ($urandom_range(0, 9))
            0:       v = 11'd0;
            1:       v = 11'($urandom_range(1024, 2047));
            2:       v = 11'($urandom_range(1, 1024));
            3:       v = 11'd1;
            default: v = 11'($urandom_range(1, 12));
        endcase
        return ($urandom & 32'hFFFF_F800) | {21'd0, v};
    endfunction

    initial
    begin
        sb            = new();
        grid_settings = 0;
        tx_calm       = 1'b1;
        rx_calm       = 1'b1;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset grid 2x2 with hard edges, back to back
        send_query(10'd0, 10'd0);
        send_query(10'd1, 10'd0);
        send_query(10'd0, 10'd1);
        send_query(10'd1, 10'd1);
        send_query(10'd2, 10'd1);
        send_query(10'd1023, 10'd1023);

        // Odd sizes round up to 6x8, both axes wrap; junk in upper data bits
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        set_grid(32'hFFFF_F805, 32'hA5A5_F807, 32'h0000_0001, 32'hFFFF_FFFF);
        send_query(10'd0, 10'd0);
        send_query(10'd5, 10'd7);
        send_query(10'd2, 10'd3);
        send_query(10'd3, 10'd4);
        send_query(10'd6, 10'd0);
        send_query(10'd0, 10'd8);

        // Narrow wrapped grid: neighbors land on the same cells
        set_grid(32'd1, 32'd1, 32'd1, 32'd1);
        send_query(10'd0, 10'd0);
        send_query(10'd1, 10'd1);

        // Zero width: everything is outside
        set_grid(32'd0, 32'd2, 32'd0, 32'd0);
        send_query(10'd0, 10'd0);

        // Oversized sides clamp to the largest grid, hard edges then wrapped
        set_grid(32'd2047, 32'd2047, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
        send_query(10'd0, 10'd0);
        send_query(10'd1023, 10'd1023);
        send_query(10'd1023, 10'd0);
        send_query(10'd0, 10'd1023);
        set_grid(32'd1500, 32'd1025, 32'd1, 32'd1);
        send_query(10'd1023, 10'd1023);
        send_query(10'd0, 10'd0);

        // Random grids and queries
        for (int ph = 0; ph < 8; ph++)
        begin
            set_grid(random_side(), random_side(), $urandom, $urandom);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 25; i++)
            begin
                if (i == 12 && (ph == 0 || $urandom_range(0, 1) == 1))
                    drain_results();
                random_query();
            end
        end

        drain_results();
        $display("%0d queries over %0d grid settings, %0d outside the grid;",
                 sb.queries, grid_settings + 1, sb.bad_queries);
        $display("%0d neighbor results checked", sb.results);
        if (sb.fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
